// ----- rtl/deq_pkg.sv -----
package deq_pkg;

    // Default number of entries in the ring.
    localparam int unsigned DEPTH_DEF = 64;

    // Field widths.
    localparam int unsigned WORD_W = 32;
    localparam int unsigned REQ_W  = 3;
    localparam int unsigned STAT_W = 2;

    // Request kinds carried on s_tuser.
    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_LIST       = 3'd4
    } req_t;

    // Result status carried on m_tuser.
    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_LIST_RD,
        S_LIST_LD
    } state_t;

    // Which ring position the read port addresses.
    typedef enum logic [1:0] {
        RD_FRONT,
        RD_BACK,
        RD_LIST
    } rd_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    push_front;
        logic    push_back;
        logic    pop_front;
        logic    pop_back;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    cnt_clr;
        logic    cnt_inc;
        logic    load_out;
        logic    out_from_mem;
        status_t out_status;
        logic    out_last;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic list_last;
        logic out_free;
    } stat_t;

endpackage

// ----- rtl/deq_ctrl.sv -----
module deq_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [deq_pkg::REQ_W-1:0]  s_tuser,
    input  deq_pkg::stat_t             stat,
    output deq_pkg::cmd_t              cmd
);
    import deq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.rd_sel     = RD_FRONT;
        cmd.out_status = STAT_OK;
        s_tready       = 1'b0;
        accept         = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = stat.out_free;
                accept   = s_tvalid && stat.out_free;
                if (accept) begin
                    case (req_t'(s_tuser))
                        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                            cmd.load_out = 1'b1;
                            cmd.out_last = 1'b1;
                            if (stat.full) begin
                                cmd.out_status = STAT_FULL;
                            end else begin
                                cmd.push_front = (req_t'(s_tuser) == REQ_PUSH_FRONT);
                                cmd.push_back  = (req_t'(s_tuser) == REQ_PUSH_BACK);
                            end
                        end
                        REQ_POP_FRONT, REQ_POP_BACK: begin
                            if (stat.empty) begin
                                cmd.load_out   = 1'b1;
                                cmd.out_last   = 1'b1;
                                cmd.out_status = STAT_EMPTY;
                            end else begin
                                cmd.rd_en     = 1'b1;
                                cmd.pop_front = (req_t'(s_tuser) == REQ_POP_FRONT);
                                cmd.pop_back  = (req_t'(s_tuser) == REQ_POP_BACK);
                                cmd.rd_sel    = (req_t'(s_tuser) == REQ_POP_FRONT) ?
                                                RD_FRONT : RD_BACK;
                                state_next    = S_POP;
                            end
                        end
                        REQ_LIST: begin
                            if (stat.empty) begin
                                cmd.load_out   = 1'b1;
                                cmd.out_last   = 1'b1;
                                cmd.out_status = STAT_EMPTY;
                            end else begin
                                cmd.cnt_clr = 1'b1;
                                state_next  = S_LIST_RD;
                            end
                        end
                        default: begin
                            // Unknown request kinds are dropped without a result.
                        end
                    endcase
                end
            end
            S_POP: begin
                // The popped word arrives from the read port this cycle.
                cmd.load_out     = 1'b1;
                cmd.out_from_mem = 1'b1;
                cmd.out_last     = 1'b1;
                state_next       = S_IDLE;
            end
            S_LIST_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_LIST;
                state_next = S_LIST_LD;
            end
            S_LIST_LD: begin
                // Hand the word on once the output register can take it.
                if (stat.out_free) begin
                    cmd.load_out     = 1'b1;
                    cmd.out_from_mem = 1'b1;
                    cmd.out_last     = stat.list_last;
                    if (stat.list_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.cnt_inc = 1'b1;
                        state_next  = S_LIST_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/deq_dp.sv -----
module deq_dp #(
    parameter int unsigned DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [deq_pkg::WORD_W-1:0]  s_tdata,
    input  deq_pkg::cmd_t               cmd,
    output deq_pkg::stat_t              stat,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [deq_pkg::WORD_W-1:0]  m_tdata,
    output logic [deq_pkg::STAT_W-1:0]  m_tuser,
    output logic                        m_tlast
);
    import deq_pkg::*;

    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned OCC_W = $clog2(DEPTH + 1);
    localparam int unsigned SUM_W = IDX_W + 1;

    logic [WORD_W-1:0] mem_reg [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]  front_reg, front_next;
    logic [OCC_W-1:0]  occ_reg, occ_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]  front_inc, front_dec;
    logic [SUM_W-1:0]  offset, sum;
    logic [IDX_W-1:0]  pos, rd_addr, wr_addr;
    logic              m_tvalid_reg;
    logic [WORD_W-1:0] word_reg;
    status_t           status_reg;
    logic              last_reg;

    // Front index stepped around the ring.
    assign front_inc = (front_reg == IDX_W'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - 1'b1;

    // Ring position of front plus an offset, wrapped by one compare and subtract.
    always_comb begin
        offset = SUM_W'(cnt_reg);
        if (cmd.push_back) begin
            offset = SUM_W'(occ_reg);
        end else if (cmd.rd_sel == RD_BACK) begin
            offset = SUM_W'(occ_reg) - 1'b1;
        end
        sum = SUM_W'(front_reg) + offset;
        if (sum >= SUM_W'(DEPTH)) begin
            pos = IDX_W'(sum - SUM_W'(DEPTH));
        end else begin
            pos = IDX_W'(sum);
        end
    end

    assign rd_addr = (cmd.rd_sel == RD_FRONT) ? front_reg : pos;
    assign wr_addr = cmd.push_front ? front_dec : pos;

    // Word store with a registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.push_front || cmd.push_back) begin
            mem_reg[wr_addr] <= s_tdata;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    // Front index, occupancy and list counter updates.
    always_comb begin
        front_next = front_reg;
        occ_next   = occ_reg;
        cnt_next   = cnt_reg;
        if (cmd.push_front) begin
            front_next = front_dec;
            occ_next   = occ_reg + 1'b1;
        end else if (cmd.push_back) begin
            occ_next   = occ_reg + 1'b1;
        end else if (cmd.pop_front) begin
            front_next = front_inc;
            occ_next   = occ_reg - 1'b1;
        end else if (cmd.pop_back) begin
            occ_next   = occ_reg - 1'b1;
        end
        if (cmd.cnt_clr) begin
            cnt_next = '0;
        end else if (cmd.cnt_inc) begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            occ_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            front_reg <= front_next;
            occ_reg   <= occ_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Status toward the controller.
    assign stat.full      = (occ_reg == OCC_W'(DEPTH));
    assign stat.empty     = (occ_reg == '0);
    assign stat.list_last = ((OCC_W'(cnt_reg) + OCC_W'(1)) == occ_reg);
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            word_reg   <= cmd.out_from_mem ? rd_data_reg : '0;
            status_reg <= cmd.out_status;
            last_reg   <= cmd.out_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = word_reg;
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;

`ifndef NO_ASSERTIONS
    // Occupancy never exceeds the ring size.
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_W'(DEPTH))
        else $error("occupancy above ring size");

    // A new result never overwrites one that has not been taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> stat.out_free)
        else $error("output register overwritten");

    // A push grows the occupancy by exactly one.
    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.push_front || cmd.push_back) |=> occ_reg == $past(occ_reg) + 1'b1)
        else $error("push did not grow occupancy");

    // Pops and pushes only happen when the store allows them.
    a_legal_update: assert property (@(posedge aclk) disable iff (!aresetn)
        !((cmd.pop_front || cmd.pop_back) && stat.empty) &&
        !((cmd.push_front || cmd.push_back) && stat.full))
        else $error("pointer update on full or empty store");

    // The list counter stays inside the stored words.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en && cmd.rd_sel == RD_LIST |-> OCC_W'(cnt_reg) < occ_reg)
        else $error("list read beyond stored words");
`endif

endmodule

// ----- rtl/double_ended_queue.sv -----
// Channel  Dir  tdata           tuser             tlast
// s_       in   push_value[31:0] req_type[2:0]    -
// m_       out  word[31:0]       status[1:0]      last
//
// A push's result is in the output register in the cycle after accept.
// A pop passes through the store's registered read port before it reaches the output register.
// A list reads its words one at a time through that read port, occupancy words in all.
// Reset (aresetn low, synchronous) empties the store; no clearing pass is needed.
// A stalled m_ channel holds its result and blocks new requests until it is taken.
module double_ended_queue #(
    parameter int unsigned DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [deq_pkg::WORD_W-1:0]  s_tdata,   // push_value[31:0]
    input  logic [deq_pkg::REQ_W-1:0]   s_tuser,   // req_type[2:0]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [deq_pkg::WORD_W-1:0]  m_tdata,   // word[31:0]
    output logic [deq_pkg::STAT_W-1:0]  m_tuser,   // status[1:0]
    output logic                        m_tlast
);
    import deq_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Request sequencing.
    deq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Ring store, pointers and output register.
    deq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
